[rtl/aarm_pkg.sv]
// Types, constants and arithmetic helpers for the axis-angle rotation matrix unit.
// Standalone package; no dependencies.
package aarm_pkg;

   // pipeline shape
   localparam int SQRT_STEPS  = 32;
   localparam int DIV_STEPS   = 31;
   localparam int TRIG_STAGES = 11;
   localparam int SC_LAST     = 1 + SQRT_STEPS + DIV_STEPS - TRIG_STAGES;
   localparam int PIPE_DEPTH  = 5 + SQRT_STEPS + DIV_STEPS;

   // angle units (Q9.7 degrees)
   localparam logic signed [18:0] TWO_TURNS = 19'sd92160;
   localparam logic [16:0] TURN_UNITS = 17'd46080;
   localparam logic [16:0] OCT_UNITS  = 17'd5760;

   // radians conversion: pi_q30 = 45 * T_A + T_B, 23040 = 45 * 512
   localparam logic [38:0] T_A = 39'd74961320;
   localparam logic [17:0] T_B = 18'd26;
   localparam int S_45 = 24;
   localparam logic [18:0] M_45 = 19'(((64'd1 << S_45) + 64'd44) / 64'd45);

   // reciprocals for exact floor division of values below 2^31
   localparam int S_42 = 37;
   localparam int S_56 = 37;
   localparam int S_20 = 36;
   localparam int S_30 = 36;
   localparam int S_6  = 34;
   localparam int S_12 = 35;
   localparam logic [31:0] M_42 = 32'(((64'd1 << S_42) + 64'd41) / 64'd42);
   localparam logic [31:0] M_56 = 32'(((64'd1 << S_56) + 64'd55) / 64'd56);
   localparam logic [31:0] M_20 = 32'(((64'd1 << S_20) + 64'd19) / 64'd20);
   localparam logic [31:0] M_30 = 32'(((64'd1 << S_30) + 64'd29) / 64'd30);
   localparam logic [31:0] M_6  = 32'(((64'd1 << S_6) + 64'd5) / 64'd6);
   localparam logic [31:0] M_12 = 32'(((64'd1 << S_12) + 64'd11) / 64'd12);

   localparam logic [30:0] ONE_U30 = 31'h4000_0000;
   localparam logic signed [33:0] ONE_Q30 = 34'sh0_4000_0000;
   localparam logic [17:0] Q14_MAX = 18'd16384;

   typedef logic signed [33:0] q30_type;
   typedef logic [30:0] uq30_type;

   typedef struct packed {
      logic signed [16:0] ang;
      logic [2:0][15:0]   axis;
   } in_type;

   typedef struct packed {
      logic [63:0]      rem;
      logic [63:0]      res;
      logic [2:0][15:0] mag;
      logic [2:0]       neg;
      logic             zero;
   } root_type;

   typedef struct packed {
      logic [31:0]      root;
      logic [2:0][62:0] rem;
      logic [2:0][30:0] quo;
      logic [2:0]       neg;
      logic             zero;
   } quot_type;

   typedef struct packed {
      logic [2:0]  oct;
      logic [12:0] t;
      logic [38:0] at;
      logic [17:0] w;
      uq30_type    x;
      uq30_type    x2;
      uq30_type    ps;
      uq30_type    pc;
   } trig_type;

   typedef struct packed {
      q30_type s;
      q30_type c;
   } sc_type;

   typedef struct packed {
      q30_type x, y, z, xx, yy, zz, xy, xz, yz, s, c, omc;
      logic    zero;
   } prod_type;

   typedef struct packed {
      q30_type xx, yy, zz, xc, yc, zc, xyo, xzo, yzo, xs, ys, zs;
      logic    zero;
   } term_type;

   typedef struct packed {
      logic [8:0][15:0] ent;
      logic             zero;
   } out_type;

   typedef struct packed {
      logic [2:0]  oct;
      logic [12:0] t;
   } octant_type;

   // unsigned Q30 product, rounded half up
   function automatic uq30_type umulq(uq30_type a, uq30_type b);
      logic [62:0] p;
      p = 63'(a) * 63'(b) + (63'd1 << 29);
      return 31'(p >> 30);
   endfunction

   // floor(v / d) as multiply by reciprocal m and shift sh
   function automatic uq30_type divc(uq30_type v, logic [31:0] m, int sh);
      logic [62:0] p;
      p = 63'(v) * 63'(m);
      return 31'(p >> sh);
   endfunction

   // signed Q30 product, ties away from zero
   function automatic q30_type smulq(q30_type a, q30_type b);
      logic [33:0] ma, mb;
      logic [63:0] p;
      ma = a[33] ? 34'(-a) : 34'(a);
      mb = b[33] ? 34'(-b) : 34'(b);
      p  = 64'(ma[31:0]) * 64'(mb[31:0]) + (64'd1 << 29);
      p  = p >> 30;
      return (a[33] != b[33]) ? -q30_type'(p[33:0]) : q30_type'(p[33:0]);
   endfunction

   // Q30 to Q14, ties away from zero, saturated
   function automatic logic [15:0] to_q14(q30_type v);
      logic [33:0] mag;
      logic [33:0] r;
      logic [17:0] q;
      mag = v[33] ? 34'(-v) : 34'(v);
      r   = (mag + 34'd32768) >> 16;
      q   = (r > 34'(Q14_MAX)) ? Q14_MAX : r[17:0];
      return v[33] ? 16'(-q) : 16'(q);
   endfunction

   // reduce angle to octant and mirrored offset
   function automatic octant_type reduce(logic signed [16:0] ang);
      logic signed [18:0] sa;
      logic [16:0] r, f;
      octant_type o;
      sa = 19'(ang);
      if (sa < 0) sa = sa + TWO_TURNS;
      r = 17'(sa);
      if (r >= TURN_UNITS) r = r - TURN_UNITS;
      if (r >= TURN_UNITS) r = r - TURN_UNITS;
      o.oct = 3'd0;
      for (int k = 1; k < 8; k++) begin
         if (r >= 17'(k) * OCT_UNITS) o.oct = 3'(k);
      end
      f = r - 17'(o.oct) * OCT_UNITS;
      o.t = o.oct[0] ? 13'(OCT_UNITS - f) : 13'(f);
      return o;
   endfunction

   // one bit of the square root
   function automatic root_type root_step(root_type a, int i);
      logic [63:0] bitv, trial;
      root_type r;
      r = a;
      bitv = 64'd1 << (62 - 2 * i);
      trial = a.res + bitv;
      if (a.rem >= trial) begin
         r.rem = a.rem - trial;
         r.res = (a.res >> 1) + bitv;
      end else begin
         r.res = a.res >> 1;
      end
      return r;
   endfunction

   // one quotient bit for all three components
   function automatic quot_type quot_step(quot_type a, int b);
      logic [62:0] sub;
      quot_type r;
      r = a;
      sub = 63'(a.root) << b;
      for (int j = 0; j < 3; j++) begin
         if (a.rem[j] >= sub) begin
            r.rem[j] = a.rem[j] - sub;
            r.quo[j][b] = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

[rtl/axis_angle_rotation_matrix_unit.sv]
// Each result is presented on the rsp_* outputs with rsp_valid high.
// Throughput: one item per cycle; busy never rises. Depth is set by the 32-step root
// and the 31-step divide, one bit per stage, with sine/cosine in a parallel pipe.
// Reset clears the valid bits of every stage; data registers are not reset.
// Top level of the axis-angle rotation matrix unit; uses aarm_pkg.
module axis_angle_rotation_matrix_unit import aarm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [16:0] req_angle_deg,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic signed [15:0] req_axis_z,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_r00,
   output logic signed [15:0] rsp_r01,
   output logic signed [15:0] rsp_r02,
   output logic signed [15:0] rsp_r10,
   output logic signed [15:0] rsp_r11,
   output logic signed [15:0] rsp_r12,
   output logic signed [15:0] rsp_r20,
   output logic signed [15:0] rsp_r21,
   output logic signed [15:0] rsp_r22,
   output logic               rsp_zero_axis
);

   logic [PIPE_DEPTH-1:0] vld_ff;
   in_type   in_ff;
   root_type sq_ff [0:SQRT_STEPS];
   root_type sq_in [0:SQRT_STEPS];
   quot_type dv_ff [0:DIV_STEPS-1];
   quot_type dv_in [0:DIV_STEPS-1];
   quot_type dv_init;
   trig_type trig_ff [1:TRIG_STAGES-1];
   trig_type trig_in [1:TRIG_STAGES-1];
   sc_type   sc_ff [0:SC_LAST];
   sc_type   sc_in;
   prod_type prod_ff, prod_in;
   term_type term_ff, term_in;
   out_type  out_ff, out_in;
   octant_type rd;

   assign busy = 1'b0;

   // valid bits advance every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], start & ~busy};
      end
   end

   // squared length and root
   always_comb begin
      logic [31:0] n2;
      logic signed [31:0] sqx, sqy, sqz;
      sqx = $signed(in_ff.axis[0]) * $signed(in_ff.axis[0]);
      sqy = $signed(in_ff.axis[1]) * $signed(in_ff.axis[1]);
      sqz = $signed(in_ff.axis[2]) * $signed(in_ff.axis[2]);
      n2  = 32'(sqx) + 32'(sqy) + 32'(sqz);
      sq_in[0].rem  = {n2, 32'd0};
      sq_in[0].res  = '0;
      sq_in[0].zero = (n2 == 32'd0);
      for (int j = 0; j < 3; j++) begin
         sq_in[0].neg[j] = in_ff.axis[j][15];
         sq_in[0].mag[j] = in_ff.axis[j][15] ? 16'(-in_ff.axis[j]) : in_ff.axis[j];
      end
      for (int i = 1; i <= SQRT_STEPS; i++) begin
         sq_in[i] = root_step(sq_ff[i-1], i - 1);
      end
   end

   // divide each magnitude by the root
   always_comb begin
      dv_init.root = sq_ff[SQRT_STEPS].res[31:0];
      dv_init.neg  = sq_ff[SQRT_STEPS].neg;
      dv_init.zero = sq_ff[SQRT_STEPS].zero;
      dv_init.quo  = '0;
      for (int j = 0; j < 3; j++) begin
         dv_init.rem[j] = {1'b0, sq_ff[SQRT_STEPS].mag[j], 46'd0}
                        + {32'd0, sq_ff[SQRT_STEPS].res[31:1]};
      end
      dv_in[0] = quot_step(dv_init, DIV_STEPS - 1);
      for (int k = 1; k < DIV_STEPS; k++) begin
         dv_in[k] = quot_step(dv_ff[k-1], DIV_STEPS - 1 - k);
      end
   end

   // sine and cosine: reduce, convert, Horner series, octant fold
   always_comb begin
      logic [36:0] fw;
      logic [38:0] xs;
      uq30_type s0, c0;
      rd = reduce(in_ff.ang);
      trig_in[1] = trig_ff[1];
      trig_in[1].oct = rd.oct;
      trig_in[1].t   = rd.t;
      for (int k = 2; k < TRIG_STAGES; k++) begin
         trig_in[k] = trig_ff[k-1];
      end
      trig_in[2].at = T_A * 39'(trig_ff[1].t);
      trig_in[2].w  = 18'(trig_ff[1].t) * T_B;
      fw = (37'(trig_ff[2].w) * 37'(M_45)) >> S_45;
      xs = (trig_ff[2].at + 39'(fw)) >> 9;
      trig_in[3].x  = xs[30:0];
      trig_in[4].x2 = umulq(trig_ff[3].x, trig_ff[3].x);
      trig_in[5].ps = divc(trig_ff[4].x2, M_42, S_42);
      trig_in[5].pc = divc(trig_ff[4].x2, M_56, S_56);
      trig_in[6].ps = umulq(trig_ff[5].x2, ONE_U30 - trig_ff[5].ps);
      trig_in[6].pc = umulq(trig_ff[5].x2, ONE_U30 - trig_ff[5].pc);
      trig_in[7].ps = divc(trig_ff[6].ps, M_20, S_20);
      trig_in[7].pc = divc(trig_ff[6].pc, M_30, S_30);
      trig_in[8].ps = umulq(trig_ff[7].x2, ONE_U30 - trig_ff[7].ps);
      trig_in[8].pc = umulq(trig_ff[7].x2, ONE_U30 - trig_ff[7].pc);
      trig_in[9].ps = divc(trig_ff[8].ps, M_6, S_6);
      trig_in[9].pc = divc(trig_ff[8].pc, M_12, S_12);
      trig_in[10].ps = umulq(trig_ff[9].x, ONE_U30 - trig_ff[9].ps);
      trig_in[10].pc = umulq(trig_ff[9].x2, ONE_U30 - trig_ff[9].pc);
      s0 = trig_ff[10].ps;
      c0 = ONE_U30 - (trig_ff[10].pc >> 1);
      case (trig_ff[10].oct)
         3'd0: begin sc_in.s =  q30_type'(s0); sc_in.c =  q30_type'(c0); end
         3'd1: begin sc_in.s =  q30_type'(c0); sc_in.c =  q30_type'(s0); end
         3'd2: begin sc_in.s =  q30_type'(c0); sc_in.c = -q30_type'(s0); end
         3'd3: begin sc_in.s =  q30_type'(s0); sc_in.c = -q30_type'(c0); end
         3'd4: begin sc_in.s = -q30_type'(s0); sc_in.c = -q30_type'(c0); end
         3'd5: begin sc_in.s = -q30_type'(c0); sc_in.c = -q30_type'(s0); end
         3'd6: begin sc_in.s = -q30_type'(c0); sc_in.c =  q30_type'(s0); end
         default: begin sc_in.s = -q30_type'(s0); sc_in.c = q30_type'(c0); end
      endcase
   end

   // unit axis, its products and one minus cosine
   always_comb begin
      q30_type u [0:2];
      for (int j = 0; j < 3; j++) begin
         u[j] = q30_type'(dv_ff[DIV_STEPS-1].quo[j]);
         if (dv_ff[DIV_STEPS-1].neg[j]) u[j] = -u[j];
      end
      prod_in.x   = u[0];
      prod_in.y   = u[1];
      prod_in.z   = u[2];
      prod_in.xx  = smulq(u[0], u[0]);
      prod_in.yy  = smulq(u[1], u[1]);
      prod_in.zz  = smulq(u[2], u[2]);
      prod_in.xy  = smulq(u[0], u[1]);
      prod_in.xz  = smulq(u[0], u[2]);
      prod_in.yz  = smulq(u[1], u[2]);
      prod_in.s   = sc_ff[SC_LAST].s;
      prod_in.c   = sc_ff[SC_LAST].c;
      prod_in.omc = ONE_Q30 - sc_ff[SC_LAST].c;
      prod_in.zero = dv_ff[DIV_STEPS-1].zero;
   end

   // Rodrigues terms
   always_comb begin
      term_in.xx  = prod_ff.xx;
      term_in.yy  = prod_ff.yy;
      term_in.zz  = prod_ff.zz;
      term_in.xc  = smulq(ONE_Q30 - prod_ff.xx, prod_ff.c);
      term_in.yc  = smulq(ONE_Q30 - prod_ff.yy, prod_ff.c);
      term_in.zc  = smulq(ONE_Q30 - prod_ff.zz, prod_ff.c);
      term_in.xyo = smulq(prod_ff.xy, prod_ff.omc);
      term_in.xzo = smulq(prod_ff.xz, prod_ff.omc);
      term_in.yzo = smulq(prod_ff.yz, prod_ff.omc);
      term_in.xs  = smulq(prod_ff.x, prod_ff.s);
      term_in.ys  = smulq(prod_ff.y, prod_ff.s);
      term_in.zs  = smulq(prod_ff.z, prod_ff.s);
      term_in.zero = prod_ff.zero;
   end

   // sum, round to Q14, force identity on a zero axis
   always_comb begin
      out_in.zero = term_ff.zero;
      if (term_ff.zero) begin
         out_in.ent = '0;
         out_in.ent[0] = 16'(Q14_MAX);
         out_in.ent[4] = 16'(Q14_MAX);
         out_in.ent[8] = 16'(Q14_MAX);
      end else begin
         out_in.ent[0] = to_q14(term_ff.xx + term_ff.xc);
         out_in.ent[1] = to_q14(term_ff.xyo - term_ff.zs);
         out_in.ent[2] = to_q14(term_ff.xzo + term_ff.ys);
         out_in.ent[3] = to_q14(term_ff.xyo + term_ff.zs);
         out_in.ent[4] = to_q14(term_ff.yy + term_ff.yc);
         out_in.ent[5] = to_q14(term_ff.yzo - term_ff.xs);
         out_in.ent[6] = to_q14(term_ff.xzo - term_ff.ys);
         out_in.ent[7] = to_q14(term_ff.yzo + term_ff.xs);
         out_in.ent[8] = to_q14(term_ff.zz + term_ff.zc);
      end
   end

   // advance data registers
   always_ff @(posedge clock) begin
      in_ff <= '{ang: req_angle_deg, axis: {req_axis_z, req_axis_y, req_axis_x}};
      for (int i = 0; i <= SQRT_STEPS; i++) sq_ff[i] <= sq_in[i];
      for (int k = 0; k < DIV_STEPS; k++) dv_ff[k] <= dv_in[k];
      for (int k = 1; k < TRIG_STAGES; k++) trig_ff[k] <= trig_in[k];
      sc_ff[0] <= sc_in;
      for (int k = 1; k <= SC_LAST; k++) sc_ff[k] <= sc_ff[k-1];
      prod_ff <= prod_in;
      term_ff <= term_in;
      out_ff  <= out_in;
   end

   assign rsp_valid     = vld_ff[PIPE_DEPTH-1];
   assign rsp_r00       = out_ff.ent[0];
   assign rsp_r01       = out_ff.ent[1];
   assign rsp_r02       = out_ff.ent[2];
   assign rsp_r10       = out_ff.ent[3];
   assign rsp_r11       = out_ff.ent[4];
   assign rsp_r12       = out_ff.ent[5];
   assign rsp_r20       = out_ff.ent[6];
   assign rsp_r21       = out_ff.ent[7];
   assign rsp_r22       = out_ff.ent[8];
   assign rsp_zero_axis = out_ff.zero;

endmodule
